// ===== rtl/core/hsfe_pkg.sv =====
`timescale 1ns / 1ps

package hsfe_pkg;

	localparam int HDR_BYTES_DEF   = 4;
	localparam int VAL_OFFSET_DEF  = 4;
	localparam int FRAME_BYTES_DEF = 52;

	localparam int NUM_VALUES   = 6;
	localparam int SPAN_BYTES   = NUM_VALUES * 8;
	localparam int WIN_MAX_BITS = 64;
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic {
		MODE_HUNT,
		MODE_COLLECT
	} hsfe_mode_t;

	// one request from the front to the back
	typedef struct packed {
		logic                    sync;
		logic                    last;
		logic [7:0]              pos;
		logic [7:0]              data;
		logic [WIN_MAX_BITS-1:0] window;
	} hsfe_op_t;

endpackage

// ===== rtl/core/hsfe_fifo.sv =====
`timescale 1ns / 1ps

module hsfe_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hsfe_pkg::hsfe_op_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output hsfe_pkg::hsfe_op_t rd_data
);
	import hsfe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	hsfe_op_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/hsfe_front.sv =====
`timescale 1ns / 1ps

module hsfe_front #(
	parameter int HEADER_BYTES = hsfe_pkg::HDR_BYTES_DEF,
	parameter int FRAME_BYTES  = hsfe_pkg::FRAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               push,
	output hsfe_pkg::hsfe_op_t push_data
);
	import hsfe_pkg::*;

	localparam int   WIN_W  = 8 * HEADER_BYTES;
	localparam int   FILL_W = $clog2(HEADER_BYTES + 1);
	localparam logic SYNC_LAST = (HEADER_BYTES >= FRAME_BYTES);

	hsfe_mode_t        mode_q;
	hsfe_mode_t        mode_d;
	logic [31:0]       pattern_q;
	logic [WIN_W-1:0]  win_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        pos_q;
	logic [WIN_W-1:0]  win_shift;
	logic [WIN_W-1:0]  pat_ext;
	logic [63:0]       pat64;
	logic [FILL_W-1:0] fill_inc;
	logic [8:0]        pos_inc;
	logic              hdr_match;
	logic              coll_last;
	logic              accepted;

	assign accepted = in_valid && !in_stall;
	// header bytes beyond the register compare against zero
	assign pat64    = {32'd0, pattern_q};
	assign pat_ext  = pat64[WIN_W-1:0];

	always_comb begin
		win_shift = (win_q >> 8) | (WIN_W'(data_byte) << (WIN_W - 8));
		fill_inc  = (fill_q < FILL_W'(HEADER_BYTES)) ? fill_q + 1'b1 : fill_q;
		hdr_match = (fill_inc == FILL_W'(HEADER_BYTES)) && (win_shift == pat_ext);
		pos_inc   = {1'b0, pos_q} + 9'd1;
		coll_last = (pos_inc >= 9'(FRAME_BYTES));
	end

	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_HUNT: begin
				if (accepted && hdr_match && !SYNC_LAST) begin
					mode_d = MODE_COLLECT;
				end
			end
			MODE_COLLECT: begin
				if (accepted && coll_last) begin
					mode_d = MODE_HUNT;
				end
			end
			default: mode_d = MODE_HUNT;
		endcase
	end

	always_comb begin
		push_data.sync   = (mode_q == MODE_HUNT);
		push_data.pos    = pos_q;
		push_data.data   = data_byte;
		push_data.window = WIN_MAX_BITS'(win_shift);
		push_data.last   = 1'b0;
		push             = 1'b0;
		case (mode_q)
			MODE_HUNT: begin
				push           = accepted && hdr_match;
				push_data.last = SYNC_LAST;
			end
			MODE_COLLECT: begin
				push           = accepted;
				push_data.last = coll_last;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_HUNT;
			pattern_q <= '0;
			win_q     <= '0;
			fill_q    <= '0;
			pos_q     <= '0;
		end else begin
			mode_q <= mode_d;
			if (cfg_we) begin
				pattern_q <= cfg_data;
			end
			if (accepted) begin
				case (mode_q)
					MODE_HUNT: begin
						if (hdr_match) begin
							win_q  <= '0;
							fill_q <= '0;
							pos_q  <= SYNC_LAST ? 8'd0 : 8'(HEADER_BYTES);
						end else begin
							win_q  <= win_shift;
							fill_q <= fill_inc;
						end
					end
					MODE_COLLECT: begin
						pos_q <= coll_last ? 8'd0 : pos_inc[7:0];
					end
					default: pos_q <= '0;
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/hsfe_back.sv =====
`timescale 1ns / 1ps

module hsfe_back #(
	parameter int HEADER_BYTES = hsfe_pkg::HDR_BYTES_DEF,
	parameter int VALUE_OFFSET = hsfe_pkg::VAL_OFFSET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_valid,
	input  hsfe_pkg::hsfe_op_t rd_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_discarded,
	output logic [63:0]        value_a,
	output logic [63:0]        value_b,
	output logic [63:0]        value_c,
	output logic [63:0]        value_d,
	output logic [63:0]        value_e,
	output logic [63:0]        value_f,
	output logic [31:0]        dropped_total
);
	import hsfe_pkg::*;

	localparam int STORE_W = SPAN_BYTES * 8;

	logic [STORE_W-1:0] store_q;
	logic [STORE_W-1:0] store_d;
	logic [STORE_W-1:0] vals_q;
	logic               bad;
	logic [31:0]        drop_q;
	logic [31:0]        drop_inc;
	logic               out_valid_q;
	logic               discard_q;
	logic               finish;

	// a non-final byte never waits on the output register
	assign pop    = rd_valid && (!rd_data.last || !out_valid_q || !out_stall);
	assign finish = pop && rd_data.last;

	always_comb begin
		int p;
		p       = 0;
		store_d = store_q;
		for (int k = 0; k < SPAN_BYTES; k++) begin
			p = VALUE_OFFSET + k;
			if (rd_data.sync) begin
				// fresh frame: matched header bytes that overlap the values, rest zero
				store_d[8*k +: 8] = (p < HEADER_BYTES) ? 8'(rd_data.window >> (8 * p)) : 8'h00;
			end else if ({1'b0, rd_data.pos} == 9'(p)) begin
				store_d[8*k +: 8] = rd_data.data;
			end
		end
	end

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < NUM_VALUES; i++) begin
			if (&store_d[64*i + 52 +: 11]) begin
				bad = 1'b1;
			end
		end
		drop_inc = (bad && (drop_q != '1)) ? drop_q + 32'd1 : drop_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			store_q <= store_d;
		end
		if (finish) begin
			vals_q    <= store_d;
			discard_q <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				drop_q      <= drop_inc;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_discarded = discard_q;
	assign dropped_total   = drop_q;
	assign value_a         = vals_q[0*64 +: 64];
	assign value_b         = vals_q[1*64 +: 64];
	assign value_c         = vals_q[2*64 +: 64];
	assign value_d         = vals_q[3*64 +: 64];
	assign value_e         = vals_q[4*64 +: 64];
	assign value_f         = vals_q[5*64 +: 64];

endmodule

// ===== rtl/core/header_sync_frame_extractor.sv =====
`timescale 1ns / 1ps

// Byte-stream frame parser. Takes one byte per cycle while in_stall is low,
// hunts for the configured header (first byte in header_pattern bits 7:0,
// header bytes past the fourth must be zero), then collects FRAME_BYTES bytes
// counted from the header start and presents six little-endian doubles found
// at VALUE_OFFSET, a discard flag set when any of them has an all-ones
// exponent, and a saturating count of discarded frames. The front end (header
// window and byte counter) feeds a two-entry request queue that the back end
// (value assembly, finiteness check, output register) drains, so a held output
// stalls the input only once the queue fills. Sustained rate is one byte per
// cycle while the queue has room; out_valid rises after the last frame byte
// passes the queue and output register. Write header_pattern only while idle.
module header_sync_frame_extractor #(
	parameter int HEADER_BYTES = hsfe_pkg::HDR_BYTES_DEF,
	parameter int VALUE_OFFSET = hsfe_pkg::VAL_OFFSET_DEF,
	parameter int FRAME_BYTES  = hsfe_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] header_pattern,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_discarded,
	output logic [63:0] value_a,
	output logic [63:0] value_b,
	output logic [63:0] value_c,
	output logic [63:0] value_d,
	output logic [63:0] value_e,
	output logic [63:0] value_f,
	output logic [31:0] dropped_total
);
	import hsfe_pkg::*;

	hsfe_op_t push_data;
	hsfe_op_t rd_data;
	logic     push;
	logic     full;
	logic     pop;
	logic     rd_valid;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	hsfe_front #(
		.HEADER_BYTES (HEADER_BYTES),
		.FRAME_BYTES  (FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (header_pattern),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.push      (push),
		.push_data (push_data)
	);

	hsfe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data)
	);

	hsfe_back #(
		.HEADER_BYTES (HEADER_BYTES),
		.VALUE_OFFSET (VALUE_OFFSET)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_valid        (rd_valid),
		.rd_data         (rd_data),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_discarded (frame_discarded),
		.value_a         (value_a),
		.value_b         (value_b),
		.value_c         (value_c),
		.value_d         (value_d),
		.value_e         (value_e),
		.value_f         (value_f),
		.dropped_total   (dropped_total)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import hsfe_pkg::*;

	localparam int HDR_N   = HDR_BYTES_DEF;
	localparam int VAL_OFS = VAL_OFFSET_DEF;
	localparam int FRAME_N = FRAME_BYTES_DEF;
	localparam int NVAL    = NUM_VALUES;
	localparam int SPAN    = SPAN_BYTES;

	localparam logic [63:0] EXP_FIELD = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] WIN_MASK  = (HDR_N >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * HDR_N)) - 64'd1);

	localparam int ITEM_TARGET    = 1350;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	typedef struct packed {
		logic                       discarded;
		logic [NVAL-1:0][63:0]      vals;
		logic [31:0]                tally;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] header_pattern = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_discarded;
	logic [63:0] value_a;
	logic [63:0] value_b;
	logic [63:0] value_c;
	logic [63:0] value_d;
	logic [63:0] value_e;
	logic [63:0] value_f;
	logic [31:0] dropped_total;

	header_sync_frame_extractor #(
		.HEADER_BYTES(HDR_N),
		.VALUE_OFFSET(VAL_OFS),
		.FRAME_BYTES(FRAME_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.header_pattern(header_pattern),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_discarded(frame_discarded),
		.value_a(value_a),
		.value_b(value_b),
		.value_c(value_c),
		.value_d(value_d),
		.value_e(value_e),
		.value_f(value_f),
		.dropped_total(dropped_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// parser state as the block should hold it
	logic [63:0]           hunt_window = '0;
	int unsigned           hunt_fill = 0;
	bit                    in_frame = 1'b0;
	logic [7:0]            byte_pos = '0;
	logic [NVAL-1:0][63:0] assembled = '0;
	logic [31:0]           discard_tally = '0;
	logic [31:0]           header_setting = '0;

	frame_result_t expected_frames[$];

	int unsigned items_sent = 0;
	int unsigned frames_predicted = 0;
	int unsigned frames_checked = 0;
	int unsigned drops_seen = 0;
	int unsigned headers_written = 0;
	int unsigned error_count = 0;
	int          burst_left = 0;
	bit          sender_steady = 1'b0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic logic [7:0] header_byte(input logic [31:0] hdr, input int k);
		if (k < 4)
			return hdr[8 * k +: 8];
		return 8'h00;
	endfunction

	task automatic place_byte(input int pos, input logic [7:0] b);
		int rel;
		rel = pos - VAL_OFS;
		if (rel >= 0 && rel < SPAN)
			assembled[rel / 8][8 * (rel % 8) +: 8] = b;
	endtask

	task automatic close_frame();
		frame_result_t r;
		bit bad;
		bad = 1'b0;
		for (int i = 0; i < NVAL; i++)
			if ((assembled[i] & EXP_FIELD) == EXP_FIELD)
				bad = 1'b1;
		if (bad && discard_tally != 32'hFFFF_FFFF)
			discard_tally++;
		r.discarded = bad;
		r.vals = assembled;
		r.tally = discard_tally;
		expected_frames = {expected_frames, r};
		frames_predicted++;
		hunt_window = '0;
		hunt_fill = 0;
		in_frame = 1'b0;
		byte_pos = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b);
		if (!in_frame) begin
			hunt_window = ((hunt_window >> 8) | (64'(b) << (8 * (HDR_N - 1)))) & WIN_MASK;
			if (hunt_fill < HDR_N)
				hunt_fill++;
			if (hunt_fill >= HDR_N && hunt_window == (64'(header_setting) & WIN_MASK)) begin
				in_frame = 1'b1;
				assembled = '0;
				for (int p = 0; p < HDR_N; p++)
					place_byte(p, hunt_window[8 * p +: 8]);
				byte_pos = 8'(HDR_N);
				if (byte_pos >= FRAME_N)
					close_frame();
			end
		end else begin
			place_byte(byte_pos, b);
			byte_pos = byte_pos + 8'd1;
			if (byte_pos >= FRAME_N || byte_pos == 8'd0)
				close_frame();
		end
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!sender_steady && burst_left <= 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_byte(b);
		items_sent++;
		@(negedge clk);
	endtask

	// hold off until every pending frame has come out
	task automatic wait_quiet();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_frames.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_header(input logic [31:0] pat);
		cfg_valid <= 1'b1;
		header_pattern <= pat;
		do @(posedge clk); while (!cfg_ready);
		header_setting = pat;
		headers_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: v[62:52] = '1;
			1: v = {v[63], 11'h7FF, 52'h0};
			2: v = {v[63], 63'h0};
			3: v = {v[63], 11'h7FE, {52{1'b1}}};
			4: v[62:52] = '0;
			default: if (v[62:52] == '1) v[52] = 1'b0;
		endcase
		return v;
	endfunction

	function automatic logic [NVAL-1:0][63:0] random_values();
		logic [NVAL-1:0][63:0] vs;
		for (int i = 0; i < NVAL; i++)
			vs[i] = pick_value();
		return vs;
	endfunction

	task automatic send_frame(input logic [31:0] hdr, input logic [NVAL-1:0][63:0] vals);
		int n;
		int rel;
		logic [7:0] b;
		n = (FRAME_N > HDR_N) ? FRAME_N : HDR_N;
		for (int p = 0; p < n; p++) begin
			rel = p - VAL_OFS;
			if (p < HDR_N)
				b = header_byte(hdr, p);
			else if (rel >= 0 && rel < SPAN)
				b = vals[rel / 8][8 * (rel % 8) +: 8];
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b);
		end
	endtask

	task automatic send_noise(input logic [31:0] hdr);
		int n;
		case ($urandom_range(0, 11))
			2, 3, 4: begin
				n = $urandom_range(1, 12);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end
			5, 6: begin
				// header cut short, then a stray byte
				n = $urandom_range(1, (HDR_N > 1) ? HDR_N - 1 : 1);
				for (int k = 0; k < n; k++)
					send_byte(header_byte(hdr, k));
				send_byte(8'($urandom_range(0, 255)));
			end
			7, 8: begin
				n = $urandom_range(1, 5);
				repeat (n) send_byte(header_byte(hdr, 0));
			end
			9: begin
				// runt frame: the next header gets swallowed as frame data
				for (int k = 0; k < HDR_N; k++)
					send_byte(header_byte(hdr, k));
				n = $urandom_range(0, 20);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	// header register still at its reset value of zero
	task automatic test_reset_header();
		send_frame(32'h0000_0000, '0);
	endtask

	task automatic test_value_extremes();
		logic [NVAL-1:0][63:0] vs;
		wait_quiet();
		write_header(32'hFFFF_FFFF);
		vs[0] = 64'h0000_0000_0000_0000;
		vs[1] = 64'h7FEF_FFFF_FFFF_FFFF;
		vs[2] = 64'h8000_0000_0000_0001;
		vs[3] = 64'hFFFF_FFFF_FFFF_FFFF;
		vs[4] = 64'h7FF0_0000_0000_0000;
		vs[5] = 64'h0010_0000_0000_0000;
		send_frame(32'hFFFF_FFFF, vs);
		vs[0] = 64'hFFEF_FFFF_FFFF_FFFF;
		vs[1] = 64'h7FEF_FFFF_FFFF_FFFF;
		vs[2] = 64'h8000_0000_0000_0000;
		vs[3] = 64'h000F_FFFF_FFFF_FFFF;
		vs[4] = 64'h0000_0000_0000_0001;
		vs[5] = 64'h7FF8_0000_0000_0001;
		send_frame(32'hFFFF_FFFF, vs);
	endtask

	// repeated and broken header starts before the real one
	task automatic test_header_hunt();
		localparam logic [31:0] HUNT_HDR = 32'hC341_4141;
		logic [NVAL-1:0][63:0] vs;
		wait_quiet();
		write_header(HUNT_HDR);
		send_byte(8'h41);
		send_byte(8'h41);
		send_byte(8'hC3);
		send_byte(8'h00);
		repeat (5) send_byte(8'h41);
		vs = random_values();
		vs[5] = {1'b1, 11'h7FF, 52'h0};
		send_frame(HUNT_HDR, vs);
	endtask

	task automatic test_random_frames();
		logic [31:0] hdr;
		int phase;
		int nframes;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: hdr = 32'h0000_0000;
				1: hdr = 32'h4141_4141;
				2: hdr = 32'hFFFF_FFFF;
				default: hdr = $urandom;
			endcase
			wait_quiet();
			write_header(hdr);
			sender_steady = ($urandom_range(0, 3) == 0);
			nframes = $urandom_range(4, 9);
			for (int f = 0; f < nframes && items_sent < ITEM_TARGET; f++) begin
				send_noise(hdr);
				send_frame(hdr, random_values());
				if ($urandom_range(0, 9) == 0)
					wait_quiet();
			end
			phase++;
		end
		sender_steady = 1'b0;
	endtask

	// receiver back-pressure, mode changes every stretch of cycles
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	always @(negedge clk) begin
		if (stall_left <= 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
			STALL_TOGGLE: out_stall <= ~out_stall;
			default: out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin : check_frames
		frame_result_t want;
		logic [NVAL-1:0][63:0] seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = {value_f, value_e, value_d, value_c, value_b, value_a};
			if (expected_frames.size() == 0) begin
				report_mismatch("frame result with no frame pending");
			end else begin
				want = expected_frames.pop_front();
				if (frame_discarded !== want.discarded)
					report_mismatch($sformatf("frame %0d frame_discarded %0b, want %0b",
						frames_checked, frame_discarded, want.discarded));
				for (int i = 0; i < NVAL; i++)
					if (seen[i] !== want.vals[i])
						report_mismatch($sformatf("frame %0d value_%c %h, want %h",
							frames_checked, 8'h61 + i, seen[i], want.vals[i]));
				if (dropped_total !== want.tally)
					report_mismatch($sformatf("frame %0d dropped_total %0d, want %0d",
						frames_checked, dropped_total, want.tally));
				if (want.discarded)
					drops_seen++;
			end
			frames_checked++;
		end
	end

	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_header();
		test_value_extremes();
		test_header_hunt();
		test_random_frames();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_frames.size() != 0)
			report_mismatch($sformatf("%0d frames never came out", expected_frames.size()));
		$display("fed %0d bytes under %0d header settings with random gaps and stalls",
			items_sent, headers_written);
		$display("checked %0d frames, %0d of them discarded, %0d mismatches",
			frames_checked, drops_seen, error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hsfe_pkg.sv
rtl/core/hsfe_fifo.sv
rtl/core/hsfe_front.sv
rtl/core/hsfe_back.sv
rtl/core/header_sync_frame_extractor.sv
dv/testbench.sv
